[hdl/uniform_cubic_bspline_sampler_core_defines.svh]
// assertion macros shared by the spline sampler rtl
`ifndef UNIFORM_CUBIC_BSPLINE_SAMPLER_CORE_DEFINES_SVH
`define UNIFORM_CUBIC_BSPLINE_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define UCBS_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UCBS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ucbs_pkg.sv]
// types, constants, microcode rom and arithmetic helpers of the spline sampler
package ucbs_pkg;

  // coordinate and sample count limits
  localparam int COORD_BITS  = 10;
  localparam int MAX_SAMPLES = 64;

  // port widths
  localparam int IN_W      = 10;
  localparam int SX_W      = 11;
  localparam int SY_W      = 10;
  localparam int SPS_W     = 7;
  localparam int XOFF_W    = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [SPS_W-1:0]  SPS_RESET  = 7'd64;
  localparam logic [XOFF_W-1:0] XOFF_RESET = 10'd150;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_SEGMENT = 1'b0,
    REG_X_OFFSET            = 1'b1
  } cfg_reg_t;

  // sample count and parameter step divider
  localparam int N_W       = $clog2(MAX_SAMPLES + 1);
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int DIV_STEPS = FRAC_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // blend arithmetic
  localparam int COEF_W      = 21;
  localparam int PROD_W      = COORD_BITS + 1 + COEF_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int SHR_W       = ACC_W - 1 - FRAC_W;
  localparam int SC_W        = COORD_BITS + 3;
  localparam int SCALED_CAP  = 6 << COORD_BITS;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_SIX = 18'd174763;
  localparam int MDIV_W      = SC_W + RECIP_W;
  localparam int QC_W        = MDIV_W - RECIP_SHIFT;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] COEF_FOUR = COEF_W'(262144);

  // drain steps after the last issue; the product stage takes that word in the last one
  localparam int DRAIN_CYCLES = 4;
  localparam int DRN_W        = 2;

  // window fill levels
  localparam int HELD_W = 3;
  localparam logic [HELD_W-1:0] HELD_SEG  = 3'd3;
  localparam logic [HELD_W-1:0] HELD_FULL = 3'd4;

  // microcode
  typedef enum logic [2:0] {
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_WAIT,
    OP_SEG_INIT,
    OP_ISSUE,
    OP_DRAIN
  } uop_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_DIV_LAST,
    CND_CLOSE,
    CND_SAMPLE_LAST,
    CND_DRAIN_LAST
  } ucond_t;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t PC_DIV_INIT = 3'd0;
  localparam upc_t PC_DIV_STEP = 3'd1;
  localparam upc_t PC_WAIT     = 3'd2;
  localparam upc_t PC_SEG      = 3'd3;
  localparam upc_t PC_ISSUE    = 3'd4;
  localparam upc_t PC_DRAIN    = 3'd5;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    logic   hold;
    upc_t   target;
  } uword_t;

  // control store: jump to target when cond holds, else stay (hold) or fall through
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: CND_ALWAYS,      hold: 1'b0, target: PC_DIV_STEP};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: CND_DIV_LAST,    hold: 1'b1, target: PC_WAIT};
      PC_WAIT:     w = '{op: OP_WAIT,     cond: CND_CLOSE,       hold: 1'b1, target: PC_SEG};
      PC_SEG:      w = '{op: OP_SEG_INIT, cond: CND_ALWAYS,      hold: 1'b0, target: PC_ISSUE};
      PC_ISSUE:    w = '{op: OP_ISSUE,    cond: CND_SAMPLE_LAST, hold: 1'b1, target: PC_DRAIN};
      PC_DRAIN:    w = '{op: OP_DRAIN,    cond: CND_DRAIN_LAST,  hold: 1'b1, target: PC_WAIT};
      default:     w = '{op: OP_DIV_INIT, cond: CND_ALWAYS,      hold: 1'b0, target: PC_DIV_STEP};
    endcase
    return w;
  endfunction

  // nonnegative floor(acc / 65536), clamped so the divide by six stays exact
  function automatic logic [SC_W-1:0] clamp_scaled(input logic signed [ACC_W-1:0] acc);
    logic [SHR_W-1:0] s;
    s = acc[ACC_W-2:FRAC_W];
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (s >= SHR_W'(SCALED_CAP)) begin
      return SC_W'(SCALED_CAP);
    end else begin
      return s[SC_W-1:0];
    end
  endfunction

  // quotient from the reciprocal product, saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [MDIV_W-1:0] m);
    logic [QC_W-1:0] q;
    q = m[MDIV_W-1:RECIP_SHIFT];
    if (q[COORD_BITS]) begin
      return '1;
    end else begin
      return q[COORD_BITS-1:0];
    end
  endfunction

endpackage

[hdl/uniform_cubic_bspline_sampler_core.sv]
// Uniform cubic B-spline sampler: microcoded sequencer plus blend pipeline.
// Fill points are taken one per cycle while the sequencer waits for input. A closing point
// stalls the input through a setup step, N issue steps (N = samples per segment) and the
// drain steps, which all hold while the output is stalled. Samples come one per cycle when not stalled.
// Reset clears the window and loads 64 samples, offset 150; after reset and after each
// samples_per_segment write a serial divide runs with the input stalled.
`include "uniform_cubic_bspline_sampler_core_defines.svh"

module uniform_cubic_bspline_sampler_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ucbs_pkg::IN_W-1:0]           in_point_x,
  input  logic [ucbs_pkg::IN_W-1:0]           in_point_y,
  input  logic                                in_restart_curve,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ucbs_pkg::SX_W-1:0]           out_sample_x,
  output logic [ucbs_pkg::SY_W-1:0]           out_sample_y,
  output logic                                out_last_sample,
  input  logic                                cfg_we,
  input  logic [ucbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucbs_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CB     = ucbs_pkg::COORD_BITS;
  localparam int N_W    = ucbs_pkg::N_W;
  localparam int FRAC_W = ucbs_pkg::FRAC_W;
  localparam int QUO_W  = ucbs_pkg::QUO_W;
  localparam int COEF_W = ucbs_pkg::COEF_W;
  localparam int PROD_W = ucbs_pkg::PROD_W;
  localparam int ACC_W  = ucbs_pkg::ACC_W;
  localparam int MDIV_W = ucbs_pkg::MDIV_W;
  localparam int HELD_W = ucbs_pkg::HELD_W;

  // configuration registers
  logic [ucbs_pkg::SPS_W-1:0]  sps_r;
  logic [ucbs_pkg::XOFF_W-1:0] xoff_r;

  // sequencer
  ucbs_pkg::upc_t   pc_r, pc_nxt;
  ucbs_pkg::uword_t uw;
  logic             cond_hit, step_en, cfg_n_wr;

  // divider
  logic [ucbs_pkg::DCNT_W-1:0] div_cnt_r;
  logic [N_W-1:0]              div_rem_r, div_rem_nxt;
  logic [QUO_W-1:0]            div_quo_r;
  logic [N_W:0]                div_trial;
  logic                        div_ge;

  // sample stepping
  logic [N_W-1:0]               n_eff;
  logic [N_W-1:0]               j_r;
  logic [N_W-1:0]               trem_r, trem_nxt;
  logic [N_W:0]                 rsum;
  logic                         rcarry;
  logic [FRAC_W-1:0]            t_r, t_nxt;
  logic [QUO_W:0]               tsum;
  logic                         sample_last;
  logic [ucbs_pkg::DRN_W-1:0]   drn_r;

  // point window
  logic [HELD_W-1:0]     held_r, held_nxt, h_eff;
  logic [3:0][CB-1:0]    win_x_r, win_y_r;
  logic [CB-1:0]         nx, ny;
  logic                  in_acc, closing;

  // pipeline
  logic                       pipe_en;
  logic                       s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic                       s7_vld_r, out_valid_r;
  logic                       s1_last_r, s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  logic                       s6_last_r, s7_last_r, out_last_r;
  logic [FRAC_W-1:0]          s1_t_r, s2_t_r, s2_t2_r, s3_t_r, s3_t2_r, s3_t3_r;
  logic [2*FRAC_W-1:0]        sq, cu;
  logic signed [COEF_W-1:0]   st, st2, st3;
  logic signed [COEF_W-1:0]   coef [4];
  logic signed [COEF_W-1:0]   s4_c_r [4];
  logic signed [PROD_W-1:0]   s5_px_r [4];
  logic signed [PROD_W-1:0]   s5_py_r [4];
  logic signed [ACC_W-1:0]    s6_accx_r, s6_accy_r;
  logic [MDIV_W-1:0]          s7_mx_r, s7_my_r;
  logic [ucbs_pkg::SX_W-1:0]  out_x_r;
  logic [ucbs_pkg::SY_W-1:0]  out_y_r;

  // handshake
  assign in_stall        = (uw.op != ucbs_pkg::OP_WAIT);
  assign in_acc          = in_valid && !in_stall;
  assign pipe_en         = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_x    = out_x_r;
  assign out_sample_y    = out_y_r;
  assign out_last_sample = out_last_r;

  // clamped sample count
  always_comb begin
    if (sps_r == '0) begin
      n_eff = N_W'(1);
    end else if (sps_r > ucbs_pkg::SPS_W'(ucbs_pkg::MAX_SAMPLES)) begin
      n_eff = N_W'(ucbs_pkg::MAX_SAMPLES);
    end else begin
      n_eff = N_W'(sps_r);
    end
  end

  // window fill decode
  assign nx       = CB'(in_point_x);
  assign ny       = CB'(in_point_y);
  assign h_eff    = in_restart_curve ? '0 : held_r;
  assign closing  = (h_eff >= ucbs_pkg::HELD_SEG);
  assign held_nxt = (h_eff >= ucbs_pkg::HELD_FULL) ? ucbs_pkg::HELD_FULL : h_eff + HELD_W'(1);

  // microcode fetch and next address
  assign uw       = ucbs_pkg::ucode_rom(pc_r);
  assign cfg_n_wr = cfg_we && (cfg_index == ucbs_pkg::REG_SAMPLES_PER_SEGMENT);
  assign step_en  = (uw.op == ucbs_pkg::OP_WAIT) ? 1'b1 : pipe_en;

  always_comb begin
    case (uw.cond)
      ucbs_pkg::CND_ALWAYS:      cond_hit = 1'b1;
      ucbs_pkg::CND_DIV_LAST:    cond_hit = (div_cnt_r == ucbs_pkg::DCNT_W'(ucbs_pkg::DIV_STEPS - 1));
      ucbs_pkg::CND_CLOSE:       cond_hit = in_acc && closing;
      ucbs_pkg::CND_SAMPLE_LAST: cond_hit = sample_last;
      ucbs_pkg::CND_DRAIN_LAST:  cond_hit = (drn_r == ucbs_pkg::DRN_W'(ucbs_pkg::DRAIN_CYCLES - 1));
      default:                   cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cfg_n_wr) begin
      pc_nxt = ucbs_pkg::PC_DIV_INIT;
    end else if (!step_en) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else if (uw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + ucbs_pkg::UPC_W'(1);
    end
  end

  // restoring divide step for 65536 / n
  assign div_trial   = {div_rem_r, (div_cnt_r == '0)};
  assign div_ge      = (div_trial >= {1'b0, n_eff});
  assign div_rem_nxt = div_ge ? N_W'(div_trial - {1'b0, n_eff}) : N_W'(div_trial);

  // parameter step: t += q, remainder carries into t
  assign rsum        = {1'b0, trem_r} + {1'b0, div_rem_r};
  assign rcarry      = (rsum >= {1'b0, n_eff});
  assign trem_nxt    = rcarry ? N_W'(rsum - {1'b0, n_eff}) : N_W'(rsum);
  assign tsum        = (QUO_W + 1)'(t_r) + (QUO_W + 1)'(div_quo_r) + (QUO_W + 1)'(rcarry);
  assign t_nxt       = tsum[FRAC_W-1:0];
  assign sample_last = (j_r == n_eff - N_W'(1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ucbs_pkg::PC_DIV_INIT;
      sps_r       <= ucbs_pkg::SPS_RESET;
      xoff_r      <= ucbs_pkg::XOFF_RESET;
      held_r      <= '0;
      div_cnt_r   <= '0;
      j_r         <= '0;
      drn_r       <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      s7_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ucbs_pkg::REG_SAMPLES_PER_SEGMENT: sps_r  <= cfg_wdata[ucbs_pkg::SPS_W-1:0];
          ucbs_pkg::REG_X_OFFSET:            xoff_r <= cfg_wdata[ucbs_pkg::XOFF_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        held_r <= held_nxt;
      end
      if (step_en) begin
        case (uw.op)
          ucbs_pkg::OP_DIV_INIT: div_cnt_r <= '0;
          ucbs_pkg::OP_DIV_STEP: div_cnt_r <= div_cnt_r + ucbs_pkg::DCNT_W'(1);
          ucbs_pkg::OP_SEG_INIT: j_r <= '0;
          ucbs_pkg::OP_ISSUE: begin
            j_r   <= j_r + N_W'(1);
            drn_r <= '0;
          end
          ucbs_pkg::OP_DRAIN:    drn_r <= drn_r + ucbs_pkg::DRN_W'(1);
          default: ;
        endcase
      end
      if (pipe_en) begin
        s1_vld_r    <= (uw.op == ucbs_pkg::OP_ISSUE);
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        s4_vld_r    <= s3_vld_r;
        s5_vld_r    <= s4_vld_r;
        s6_vld_r    <= s5_vld_r;
        s7_vld_r    <= s6_vld_r;
        out_valid_r <= s7_vld_r;
      end
    end
  end

  // divider and parameter stepping datapath
  always_ff @(posedge clk) begin
    if (step_en) begin
      case (uw.op)
        ucbs_pkg::OP_DIV_INIT: begin
          div_rem_r <= '0;
          div_quo_r <= '0;
        end
        ucbs_pkg::OP_DIV_STEP: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= {div_quo_r[QUO_W-2:0], div_ge};
        end
        ucbs_pkg::OP_SEG_INIT: begin
          t_r    <= '0;
          trem_r <= '0;
        end
        ucbs_pkg::OP_ISSUE: begin
          t_r    <= t_nxt;
          trem_r <= trem_nxt;
        end
        default: ;
      endcase
    end
  end

  // point window, oldest first; slides once a segment has been formed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (h_eff >= ucbs_pkg::HELD_FULL) begin
        win_x_r <= {nx, win_x_r[3], win_x_r[2], win_x_r[1]};
        win_y_r <= {ny, win_y_r[3], win_y_r[2], win_y_r[1]};
      end else begin
        win_x_r[h_eff[1:0]] <= nx;
        win_y_r[h_eff[1:0]] <= ny;
      end
    end
  end

  // powers of t and blend coefficients
  assign sq  = s1_t_r * s1_t_r;
  assign cu  = s2_t2_r * s2_t_r;
  assign st  = $signed(COEF_W'(s3_t_r));
  assign st2 = $signed(COEF_W'(s3_t2_r));
  assign st3 = $signed(COEF_W'(s3_t3_r));

  always_comb begin
    coef[0] = ucbs_pkg::COEF_ONE - (st + st + st) + (st2 + st2 + st2) - st3;
    coef[1] = ucbs_pkg::COEF_FOUR - ((st2 <<< 2) + (st2 <<< 1)) + (st3 + st3 + st3);
    coef[2] = ucbs_pkg::COEF_ONE + (st + st + st) + (st2 + st2 + st2) - (st3 + st3 + st3);
    coef[3] = st3;
  end

  // blend pipeline
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_t_r    <= t_r;
      s1_last_r <= sample_last;

      s2_t_r    <= s1_t_r;
      s2_t2_r   <= sq[2*FRAC_W-1:FRAC_W];
      s2_last_r <= s1_last_r;

      s3_t_r    <= s2_t_r;
      s3_t2_r   <= s2_t2_r;
      s3_t3_r   <= cu[2*FRAC_W-1:FRAC_W];
      s3_last_r <= s2_last_r;

      for (int k = 0; k < 4; k++) begin
        s4_c_r[k]  <= coef[k];
        s5_px_r[k] <= $signed({1'b0, win_x_r[k]}) * s4_c_r[k];
        s5_py_r[k] <= $signed({1'b0, win_y_r[k]}) * s4_c_r[k];
      end
      s4_last_r <= s3_last_r;
      s5_last_r <= s4_last_r;

      s6_accx_r <= ACC_W'(s5_px_r[0]) + ACC_W'(s5_px_r[1]) + ACC_W'(s5_px_r[2])
                 + ACC_W'(s5_px_r[3]);
      s6_accy_r <= ACC_W'(s5_py_r[0]) + ACC_W'(s5_py_r[1]) + ACC_W'(s5_py_r[2])
                 + ACC_W'(s5_py_r[3]);
      s6_last_r <= s5_last_r;

      s7_mx_r   <= ucbs_pkg::clamp_scaled(s6_accx_r) * ucbs_pkg::RECIP_SIX;
      s7_my_r   <= ucbs_pkg::clamp_scaled(s6_accy_r) * ucbs_pkg::RECIP_SIX;
      s7_last_r <= s6_last_r;

      out_x_r    <= ucbs_pkg::SX_W'(ucbs_pkg::sat_coord(s7_mx_r)) + ucbs_pkg::SX_W'(xoff_r);
      out_y_r    <= ucbs_pkg::SY_W'(ucbs_pkg::sat_coord(s7_my_r));
      out_last_r <= s7_last_r;
    end
  end

  // checks
  `UCBS_ASSERT_NEXT(a_close_starts_seg, clk, rst_n, in_acc && closing && !cfg_n_wr, pc_r == ucbs_pkg::PC_SEG, "closing point did not start a segment")
  `UCBS_ASSERT_SAME(a_issue_in_range, clk, rst_n, uw.op == ucbs_pkg::OP_ISSUE, (j_r < n_eff) && (trem_r < n_eff), "sample index or step remainder out of range")
  `UCBS_ASSERT_NEXT(a_window_stable, clk, rst_n, uw.op == ucbs_pkg::OP_ISSUE || uw.op == ucbs_pkg::OP_DRAIN, $stable(win_x_r) && $stable(win_y_r) && $stable(held_r), "window changed while samples in flight")

endmodule
